/* rtl/ppp_pkg.sv */
`timescale 1ns / 1ps

package ppp_pkg;

    localparam int DEF_COORD_BITS = 24;
    localparam int T_FRAC         = 16;
    localparam int T_BITS         = T_FRAC + 1;
    localparam int T_ONE          = 1 << T_FRAC;
    localparam int ROUND_HALF     = 1 << (T_FRAC - 1);
    localparam int DIST_BITS      = 25;
    localparam int ARC_BITS       = 32;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [ARC_BITS-1:0]  ARC_MAX  = '1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DIFF,
        OP_MUL,
        OP_LEN,
        OP_SEG,
        OP_DOT,
        OP_PX,
        OP_EX,
        OP_PY,
        OP_EY,
        OP_ROOT,
        OP_PA,
        OP_SCORE,
        OP_EMIT
    } op_t;

    // operand pair for the shift-add multiplier
    typedef enum logic [2:0] {
        MS_DX,
        MS_DY,
        MS_RXDX,
        MS_RYDY,
        MS_EX,
        MS_EY
    } mul_sel_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t mul_sel;
        logic     mul_clear;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic sq_busy;
        logic dv_busy;
        logic out_free;
        logic item_first;
        logic item_last;
    } stat_t;

endpackage

/* rtl/ppp_ctrl.sv */
`timescale 1ns / 1ps

module ppp_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ppp_pkg::stat_t  st,
    output ppp_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_MDX,
        S_MDY,
        S_LEN,
        S_SEG,
        S_MRX,
        S_MRY,
        S_DOT,
        S_PX,
        S_EX,
        S_PY,
        S_EY,
        S_MEX,
        S_MEY,
        S_ROOT,
        S_PA,
        S_SCORE,
        S_EMIT,
        S_WAIT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   unit_busy;

    assign unit_busy = st.mul_busy | st.sq_busy | st.dv_busy;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd.op        = ppp_pkg::OP_NONE;
        cmd.mul_sel   = ppp_pkg::MS_DX;
        cmd.mul_clear = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = ppp_pkg::OP_CAPTURE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // a first word that does not close the path only opens it
                state_next = (st.item_first && !st.item_last) ? S_IDLE : S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = ppp_pkg::OP_DIFF;
                state_next = S_MDX;
            end
            S_MDX:
            begin
                cmd.op        = ppp_pkg::OP_MUL;
                cmd.mul_sel   = ppp_pkg::MS_DX;
                cmd.mul_clear = 1'b1;
                state_next    = S_WAIT;
                ret_next      = S_MDY;
            end
            S_MDY:
            begin
                cmd.op      = ppp_pkg::OP_MUL;
                cmd.mul_sel = ppp_pkg::MS_DY;
                state_next  = S_WAIT;
                ret_next    = S_LEN;
            end
            S_LEN:
            begin
                cmd.op     = ppp_pkg::OP_LEN;
                state_next = S_WAIT;
                ret_next   = S_SEG;
            end
            S_SEG:
            begin
                cmd.op     = ppp_pkg::OP_SEG;
                state_next = S_MRX;
            end
            S_MRX:
            begin
                cmd.op        = ppp_pkg::OP_MUL;
                cmd.mul_sel   = ppp_pkg::MS_RXDX;
                cmd.mul_clear = 1'b1;
                state_next    = S_WAIT;
                ret_next      = S_MRY;
            end
            S_MRY:
            begin
                cmd.op      = ppp_pkg::OP_MUL;
                cmd.mul_sel = ppp_pkg::MS_RYDY;
                state_next  = S_WAIT;
                ret_next    = S_DOT;
            end
            S_DOT:
            begin
                cmd.op     = ppp_pkg::OP_DOT;
                state_next = S_WAIT;
                ret_next   = S_PX;
            end
            S_PX:
            begin
                cmd.op     = ppp_pkg::OP_PX;
                state_next = S_EX;
            end
            S_EX:
            begin
                cmd.op     = ppp_pkg::OP_EX;
                state_next = S_PY;
            end
            S_PY:
            begin
                cmd.op     = ppp_pkg::OP_PY;
                state_next = S_EY;
            end
            S_EY:
            begin
                cmd.op     = ppp_pkg::OP_EY;
                state_next = S_MEX;
            end
            S_MEX:
            begin
                cmd.op        = ppp_pkg::OP_MUL;
                cmd.mul_sel   = ppp_pkg::MS_EX;
                cmd.mul_clear = 1'b1;
                state_next    = S_WAIT;
                ret_next      = S_MEY;
            end
            S_MEY:
            begin
                cmd.op      = ppp_pkg::OP_MUL;
                cmd.mul_sel = ppp_pkg::MS_EY;
                state_next  = S_WAIT;
                ret_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.op     = ppp_pkg::OP_ROOT;
                state_next = S_WAIT;
                ret_next   = S_PA;
            end
            S_PA:
            begin
                cmd.op     = ppp_pkg::OP_PA;
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                cmd.op     = ppp_pkg::OP_SCORE;
                state_next = st.item_last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the output register can take a new word
                if (st.out_free)
                begin
                    cmd.op     = ppp_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (!unit_busy)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

/* rtl/ppp_datapath.sv */
`timescale 1ns / 1ps

module ppp_datapath
#(
    parameter int COORD_BITS = ppp_pkg::DEF_COORD_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppp_pkg::cmd_t                        cmd,
    output ppp_pkg::stat_t                       st,
    input  logic signed [COORD_BITS-1:0]         query_x,
    input  logic signed [COORD_BITS-1:0]         query_y,
    input  logic signed [COORD_BITS-1:0]         vertex_x,
    input  logic signed [COORD_BITS-1:0]         vertex_y,
    input  logic                                 first,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ppp_pkg::DIST_BITS-1:0]        distance,
    output logic [ppp_pkg::ARC_BITS-1:0]         arc_position
);

    localparam int DW   = COORD_BITS + 1;
    localparam int L2W  = 2 * DW;
    localparam int EMW  = COORD_BITS + 17;
    localparam int EW   = EMW + 1;
    localparam int ACW  = 2 * EMW + 2;
    localparam int RW   = EMW + 1;
    localparam int TW   = ppp_pkg::T_BITS;
    localparam int QW   = ppp_pkg::T_FRAC;
    localparam int SCW  = $clog2(RW + 1);
    localparam int DCW  = $clog2(QW + 1);
    localparam int PW   = TW + DW;
    localparam int DSW  = (RW + 1 > ppp_pkg::DIST_BITS + 1) ? RW + 1 : ppp_pkg::DIST_BITS + 1;
    localparam int ASW  = ((PW > ppp_pkg::ARC_BITS) ? PW : ppp_pkg::ARC_BITS) + 1;
    localparam int AAW  = ppp_pkg::ARC_BITS + 1;

    // path state
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, prev_x_reg, prev_y_reg;
    logic [ppp_pkg::ARC_BITS-1:0]  arc_acc_reg, best_arc_reg;
    logic [ppp_pkg::DIST_BITS-1:0] best_dist_reg;
    logic                          best_valid_reg, item_first_reg, item_last_reg;

    // segment working registers
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DW-1:0]         dx_reg, dy_reg, rx_reg, ry_reg;
    logic [L2W-1:0]               len2_reg;
    logic [DW-1:0]                seglen_reg;
    logic [TW-1:0]                t_reg;
    logic signed [EW-1:0]         prod_reg, ex_reg, ey_reg;
    logic [PW-1:0]                arc_prod_reg;

    // shift-add multiplier
    logic signed [ACW-1:0] acc_reg;
    logic [ACW-1:0]        mul_a_reg;
    logic [EMW-1:0]        mul_b_reg;
    logic                  mul_neg_reg;

    // restoring square root
    logic [ACW-1:0]  sq_rad_reg;
    logic [RW+2:0]   sq_rem_reg;
    logic [RW-1:0]   sq_root_reg;
    logic [SCW-1:0]  sq_cnt_reg;

    // restoring divider for t
    logic [L2W-1:0]  dv_rem_reg;
    logic [QW-1:0]   dv_q_reg;
    logic [DCW-1:0]  dv_cnt_reg;

    // output register
    logic                          out_valid_reg;
    logic [ppp_pkg::DIST_BITS-1:0] distance_reg;
    logic [ppp_pkg::ARC_BITS-1:0]  arc_reg;

    logic [DW-1:0]   dx_mag, dy_mag, rx_mag, ry_mag;
    logic [EMW-1:0]  ex_mag, ey_mag;
    logic [EMW-1:0]  op_a, op_b;
    logic            op_neg;
    logic [ACW-1:0]  addend;
    logic [RW+2:0]   sq_sh, sq_trial;
    logic            sq_ge;
    logic [L2W:0]    dv_sh;
    logic            dv_ge;
    logic            dot_neg, dot_ge, len_zero;
    logic [TW-1:0]   t_eff;
    logic signed [DW-1:0]      px_factor;
    logic signed [TW+DW:0]     px_full;
    logic [DSW-1:0]  dsum, dval;
    logic [ppp_pkg::DIST_BITS-1:0] dist_val;
    logic [ASW-1:0]  asum;
    logic [ppp_pkg::ARC_BITS-1:0]  arc_val;
    logic [AAW-1:0]  accsum;
    logic            out_free;

    assign dx_mag = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign dy_mag = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign rx_mag = rx_reg[DW-1] ? DW'(-rx_reg) : DW'(rx_reg);
    assign ry_mag = ry_reg[DW-1] ? DW'(-ry_reg) : DW'(ry_reg);
    assign ex_mag = ex_reg[EW-1] ? EMW'(-ex_reg) : EMW'(ex_reg);
    assign ey_mag = ey_reg[EW-1] ? EMW'(-ey_reg) : EMW'(ey_reg);

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        case (cmd.mul_sel)
            ppp_pkg::MS_DX:
            begin
                op_a = EMW'(dx_mag);
                op_b = EMW'(dx_mag);
            end
            ppp_pkg::MS_DY:
            begin
                op_a = EMW'(dy_mag);
                op_b = EMW'(dy_mag);
            end
            ppp_pkg::MS_RXDX:
            begin
                op_a   = EMW'(rx_mag);
                op_b   = EMW'(dx_mag);
                op_neg = rx_reg[DW-1] ^ dx_reg[DW-1];
            end
            ppp_pkg::MS_RYDY:
            begin
                op_a   = EMW'(ry_mag);
                op_b   = EMW'(dy_mag);
                op_neg = ry_reg[DW-1] ^ dy_reg[DW-1];
            end
            ppp_pkg::MS_EX:
            begin
                op_a = ex_mag;
                op_b = ex_mag;
            end
            ppp_pkg::MS_EY:
            begin
                op_a = ey_mag;
                op_b = ey_mag;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign addend   = mul_neg_reg ? (~mul_a_reg + 1'b1) : mul_a_reg;

    assign sq_sh    = {sq_rem_reg[RW:0], sq_rad_reg[ACW-1 -: 2]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign dv_sh    = {dv_rem_reg, 1'b0};
    assign dv_ge    = (dv_sh >= {1'b0, len2_reg});

    assign len_zero = (len2_reg == '0);
    assign dot_neg  = acc_reg[ACW-1];
    assign dot_ge   = (acc_reg[ACW-2:0] >= (ACW-1)'(len2_reg));

    assign t_eff    = t_reg | TW'(dv_q_reg);

    assign px_factor = (cmd.op == ppp_pkg::OP_PY) ? dy_reg : dx_reg;
    assign px_full   = $signed({1'b0, t_eff}) * px_factor;

    assign dsum     = DSW'(sq_root_reg) + DSW'(ppp_pkg::ROUND_HALF);
    assign dval     = dsum >> QW;
    assign dist_val = (dval > DSW'(ppp_pkg::DIST_MAX)) ? ppp_pkg::DIST_MAX
                                                       : dval[ppp_pkg::DIST_BITS-1:0];
    assign asum     = ASW'(arc_acc_reg)
                    + ((ASW'(arc_prod_reg) + ASW'(ppp_pkg::ROUND_HALF)) >> QW);
    assign arc_val  = (asum > ASW'(ppp_pkg::ARC_MAX)) ? ppp_pkg::ARC_MAX
                                                      : asum[ppp_pkg::ARC_BITS-1:0];
    assign accsum   = AAW'(arc_acc_reg) + AAW'(seglen_reg);

    assign out_free = !out_valid_reg || !out_stall;

    // control and path state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_b_reg      <= '0;
            sq_cnt_reg     <= '0;
            dv_cnt_reg     <= '0;
            qx_reg         <= '0;
            qy_reg         <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            arc_acc_reg    <= '0;
            best_dist_reg  <= ppp_pkg::DIST_MAX;
            best_arc_reg   <= '0;
            best_valid_reg <= 1'b0;
            item_first_reg <= 1'b0;
            item_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == ppp_pkg::OP_MUL)
            begin
                mul_b_reg <= op_b;
            end
            else
            begin
                mul_b_reg <= mul_b_reg >> 1;
            end

            if (cmd.op == ppp_pkg::OP_LEN || cmd.op == ppp_pkg::OP_ROOT)
            begin
                sq_cnt_reg <= SCW'(RW);
            end
            else if (sq_cnt_reg != '0)
            begin
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            end

            if (cmd.op == ppp_pkg::OP_DOT)
            begin
                dv_cnt_reg <= (len_zero || dot_neg || dot_ge) ? '0 : DCW'(QW);
            end
            else if (dv_cnt_reg != '0)
            begin
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
            end

            if (cmd.op == ppp_pkg::OP_CAPTURE)
            begin
                item_first_reg <= first;
                item_last_reg  <= last;
                prev_x_reg     <= vertex_x;
                prev_y_reg     <= vertex_y;
                if (first)
                begin
                    // open a new path: drop whatever was in progress
                    qx_reg         <= query_x;
                    qy_reg         <= query_y;
                    arc_acc_reg    <= '0;
                    best_dist_reg  <= ppp_pkg::DIST_MAX;
                    best_arc_reg   <= '0;
                    best_valid_reg <= 1'b0;
                end
            end

            if (cmd.op == ppp_pkg::OP_SCORE)
            begin
                arc_acc_reg <= accsum[ppp_pkg::ARC_BITS] ? ppp_pkg::ARC_MAX
                                                         : accsum[ppp_pkg::ARC_BITS-1:0];
                // strictly smaller only, so the earlier segment keeps a tie
                if (!best_valid_reg || dist_val < best_dist_reg)
                begin
                    best_dist_reg  <= dist_val;
                    best_arc_reg   <= arc_val;
                    best_valid_reg <= 1'b1;
                end
            end

            if (cmd.op == ppp_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ppp_pkg::OP_CAPTURE:
            begin
                ax_reg <= first ? vertex_x : prev_x_reg;
                ay_reg <= first ? vertex_y : prev_y_reg;
                bx_reg <= vertex_x;
                by_reg <= vertex_y;
            end
            ppp_pkg::OP_DIFF:
            begin
                dx_reg <= DW'(bx_reg) - DW'(ax_reg);
                dy_reg <= DW'(by_reg) - DW'(ay_reg);
                rx_reg <= DW'(qx_reg) - DW'(ax_reg);
                ry_reg <= DW'(qy_reg) - DW'(ay_reg);
            end
            ppp_pkg::OP_LEN:
            begin
                len2_reg <= acc_reg[L2W-1:0];
            end
            ppp_pkg::OP_SEG:
            begin
                seglen_reg <= sq_root_reg[DW-1:0];
            end
            ppp_pkg::OP_DOT:
            begin
                t_reg <= (!len_zero && !dot_neg && dot_ge) ? TW'(ppp_pkg::T_ONE) : '0;
            end
            ppp_pkg::OP_PX, ppp_pkg::OP_PY:
            begin
                prod_reg <= px_full[EW-1:0];
            end
            ppp_pkg::OP_EX:
            begin
                ex_reg <= (EW'(rx_reg) <<< QW) - prod_reg;
            end
            ppp_pkg::OP_EY:
            begin
                ey_reg <= (EW'(ry_reg) <<< QW) - prod_reg;
            end
            ppp_pkg::OP_PA:
            begin
                arc_prod_reg <= PW'(t_eff) * PW'(seglen_reg);
            end
            ppp_pkg::OP_EMIT:
            begin
                distance_reg <= best_dist_reg;
                arc_reg      <= best_arc_reg;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase

        // multiplier: add one shifted partial product per cycle
        if (cmd.op == ppp_pkg::OP_MUL)
        begin
            mul_a_reg   <= ACW'(op_a);
            mul_neg_reg <= op_neg;
            if (cmd.mul_clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (mul_b_reg != '0)
        begin
            if (mul_b_reg[0])
            begin
                acc_reg <= acc_reg + $signed(addend);
            end
            mul_a_reg <= mul_a_reg << 1;
        end

        // square root: one result bit per cycle
        if (cmd.op == ppp_pkg::OP_LEN || cmd.op == ppp_pkg::OP_ROOT)
        begin
            sq_rad_reg  <= acc_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_cnt_reg != '0)
        begin
            sq_rem_reg  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            sq_root_reg <= {sq_root_reg[RW-2:0], sq_ge};
            sq_rad_reg  <= sq_rad_reg << 2;
        end

        // divider: one quotient bit of t per cycle
        if (cmd.op == ppp_pkg::OP_DOT)
        begin
            dv_rem_reg <= acc_reg[L2W-1:0];
            dv_q_reg   <= '0;
        end
        else if (dv_cnt_reg != '0)
        begin
            dv_rem_reg <= dv_ge ? L2W'(dv_sh - {1'b0, len2_reg}) : L2W'(dv_sh);
            dv_q_reg   <= {dv_q_reg[QW-2:0], dv_ge};
        end
    end

    assign st.mul_busy   = (mul_b_reg != '0);
    assign st.sq_busy    = (sq_cnt_reg != '0);
    assign st.dv_busy    = (dv_cnt_reg != '0);
    assign st.out_free   = out_free;
    assign st.item_first = item_first_reg;
    assign st.item_last  = item_last_reg;

    assign out_valid    = out_valid_reg;
    assign distance     = distance_reg;
    assign arc_position = arc_reg;

endmodule

/* rtl/point_to_polyline_projection_core.sv */
`timescale 1ns / 1ps
// A word that opens a path without closing it is only captured and checked; every other
// word is scored as one segment, and the multiplier stops early once no set bit is left in
// its operand. A t clamped to 0 or 1 skips the divider; a closing word adds a step that
// loads the result. Throughput: one word at a time; the next word is taken once scoring
// ends, or, for a closing word, once the result is loaded into the output register.
// Reset: asynchronous, active low; clears the held query, the path state and the output valid flag.
module point_to_polyline_projection_core
#(
    parameter int COORD_BITS = ppp_pkg::DEF_COORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  query_x,
    input  logic signed [COORD_BITS-1:0]  query_y,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    input  logic                          first,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ppp_pkg::DIST_BITS-1:0] distance,
    output logic [ppp_pkg::ARC_BITS-1:0]  arc_position
);

    // The controller steps each segment through: differences, squared length,
    // segment length (square root), dot product, t (divider, or clamp to 0 or 1),
    // error vector, squared error, distance (square root), arc and best-so-far.
    // The output register parts the result word from the input side, so a new
    // word is taken while a result still waits downstream.
    ppp_pkg::cmd_t  cmd;
    ppp_pkg::stat_t st;

    ppp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ppp_datapath
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .query_x      (query_x),
        .query_y      (query_y),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .arc_position (arc_position)
    );

    // no iterative unit may still run while a new word can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(st.mul_busy || st.sq_busy || st.dv_busy))
        else $error("iterative unit busy while idle");

    // a result word is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ppp_pkg::OP_EMIT) |-> st.out_free)
        else $error("result loaded over a stalled word");

    // a multiplication never starts on top of a running one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ppp_pkg::OP_MUL) |-> !st.mul_busy)
        else $error("multiplier restarted while busy");

    // a square root never starts on top of a running one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ppp_pkg::OP_LEN || cmd.op == ppp_pkg::OP_ROOT) |-> !st.sq_busy)
        else $error("square root restarted while busy");

endmodule
